FILE: src/substring_first_match_top_defines.svh
// Assertion macros used by the checker file of the substring search block.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SUBSTRING_FIRST_MATCH_TOP_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_TOP_DEFINES_SVH

// Same-cycle implication: the consequent must hold in the cycle of the antecedent.
`define SFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sfm_pkg.sv
package sfm_pkg;

    localparam int MAX_PATTERN_LEN = 16;
    localparam int MAX_TEXT_LEN    = 65536;
    localparam int WIN_DEPTH       = 16;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 5;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int INDEX_W         = 16;
    localparam int PAT_W           = 2 * CFG_W;
    localparam int SLOT_W          = $clog2(WIN_DEPTH);
    // Holds every position up to the limit plus one overflow marker value.
    localparam int POS_W           = $clog2(MAX_TEXT_LEN + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    // One accepted input word as seen by the position tracker.
    typedef struct packed {
        logic accept;
        logic last;
    } step_t;

    // Result word for the text that ends with the current byte.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } result_t;

    // Pattern length limited to the supported maximum.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        return (raw > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN) : raw;
    endfunction

    // Pattern byte that window slot 'slot' must equal: slot 0 holds the newest
    // byte, which lines up with the final pattern byte.
    function automatic logic [BYTE_W-1:0] slot_pattern_byte(
        input logic [PAT_W-1:0]  pat,
        input logic [LEN_W-1:0]  len,
        input logic [SLOT_W-1:0] slot
    );
        logic [LEN_W-1:0] sel;
        sel = len - LEN_W'(1) - LEN_W'(slot);
        return pat[sel[SLOT_W-1:0]*BYTE_W +: BYTE_W];
    endfunction

endpackage

FILE: src/substring_first_match_top.sv
// Channel   Direction  Handshake              Word
// input     in         in_valid / in_ready    text_byte, last_byte
// result    out        out_valid / out_ready  found, match_index, text_overflow
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// One text byte is accepted per cycle while no stalled result holds the input;
// a result word appears in the cycle after the last byte of a text is accepted.
// The 16-cell window chain and the single output register set this rate: every
// compare finishes in the accept cycle. Reset clears the position counter, the
// match record and the output valid flag; no clearing pass is needed. A stalled
// result blocks input only while the output register is full and not being taken.
module substring_first_match_top
    import sfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [INDEX_W-1:0]   match_index,
    output logic                 text_overflow
);

    // Configuration registers.
    logic [LEN_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] pattern_low_reg;
    logic [CFG_W-1:0] pattern_high_reg;

    // Output register.
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_word_reg;

    logic                      accept;
    logic [LEN_W-1:0]          len_eff;
    logic [PAT_W-1:0]          pattern;
    logic [WIN_DEPTH-1:0]      cell_ok;
    logic [BYTE_W-1:0]         cell_byte [WIN_DEPTH];
    step_t                     step;
    result_t                   result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign len_eff = eff_len(pattern_length_reg);
    assign pattern = {pattern_high_reg, pattern_low_reg};

    // The input may advance whenever the output register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Window chain: slot 0 takes the new byte and every slot hands its byte to
    // the next one on each accepted word. Each cell checks its incoming byte
    // against the pattern byte that lines up with it under the current length.
    for (genvar k = 0; k < WIN_DEPTH; k++)
    begin : g_cell
        logic [BYTE_W-1:0] byte_in;

        if (k == 0)
        begin : g_head
            assign byte_in = text_byte;
        end
        else
        begin : g_body
            assign byte_in = cell_byte[k-1];
        end

        sfm_cell u_cell (
            .clk          (clk),
            .shift_en     (accept),
            .byte_in      (byte_in),
            .in_use       (LEN_W'(k) < len_eff),
            .pattern_byte (slot_pattern_byte(pattern, len_eff, SLOT_W'(k))),
            .byte_out     (cell_byte[k]),
            .match_ok     (cell_ok[k])
        );
    end

    assign step.accept = accept;
    assign step.last   = last_byte;

    sfm_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .len       (len_eff),
        .window_eq (&cell_ok),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_word_reg.found;
    assign match_index   = out_word_reg.index;
    assign text_overflow = out_word_reg.overflow;

endmodule

FILE: src/sfm_cell.sv
module sfm_cell
    import sfm_pkg::*;
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              in_use,
    input  logic [BYTE_W-1:0] pattern_byte,
    output logic [BYTE_W-1:0] byte_out,
    output logic              match_ok
);

    logic [BYTE_W-1:0] byte_reg;

    // The compare looks at the byte arriving this cycle, which is the value
    // the slot holds after the shift.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign match_ok = !in_use || (byte_in == pattern_byte);

endmodule

FILE: src/sfm_tracker.sv
module sfm_tracker
    import sfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  step_t            step,
    input  logic [LEN_W-1:0] len,
    input  logic             window_eq,
    output result_t          result
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               seen_reg;
    logic               seen_next;
    logic [INDEX_W-1:0] start_reg;
    logic [INDEX_W-1:0] start_next;

    logic               active;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   start_full;
    logic               hit;

    assign active     = (pos_reg < POS_W'(MAX_TEXT_LEN));
    assign pos_inc    = pos_reg + POS_W'(1);
    assign start_full = pos_inc - POS_W'(len);
    assign hit        = active && (len != '0) && !seen_reg &&
                        (pos_inc >= POS_W'(len)) && window_eq;

    always_comb
    begin
        result.overflow = !active;
        if (len == '0)
        begin
            result.found = 1'b1;
            result.index = '0;
        end
        else if (seen_reg)
        begin
            result.found = 1'b1;
            result.index = start_reg;
        end
        else if (hit)
        begin
            result.found = 1'b1;
            result.index = start_full[INDEX_W-1:0];
        end
        else
        begin
            result.found = 1'b0;
            result.index = '0;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        start_next = start_reg;
        if (step.accept)
        begin
            if (step.last)
            begin
                pos_next   = '0;
                seen_next  = 1'b0;
                start_next = '0;
            end
            else
            begin
                // Past the limit the counter parks one above it to mark overflow.
                pos_next  = active ? pos_inc : POS_W'(MAX_TEXT_LEN + 1);
                seen_next = seen_reg || hit;
                if (hit)
                begin
                    start_next = start_full[INDEX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: src/sfm_checker.sv
`include "substring_first_match_top_defines.svh"

module sfm_checker
    import sfm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               last_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic               found,
    input logic [INDEX_W-1:0] match_index,
    input logic               text_overflow
);

    `SFM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(match_index) && $stable(text_overflow), "result word changed while stalled")
    `SFM_ASSERT_NOW(a_index_zero, out_valid && !found, match_index == '0, "nonzero index without a match")
    `SFM_ASSERT_NEXT(a_last_gives_word, in_valid && in_ready && last_byte, out_valid, "last byte gave no result word")
    `SFM_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !last_byte && !(out_valid && !out_ready), !out_valid, "result word without a last byte")
    `SFM_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken while result slot full")

endmodule

bind substring_first_match_top sfm_checker u_sfm_checker (.*);

FILE: bench/tb.sv
`default_nettype none

// Testbench for the streaming first-occurrence substring search.
//
// The input channel carries one text byte per word, with a flag on the final
// byte of each text. The block answers each finished text with one result
// word: whether the configured pattern occurred, where it first started, and
// whether the text ran past the position range.
//
// A predictor below keeps its own copy of the search window, the position
// counter and the first-match record. It advances on every accepted input
// word and queues one expected result word whenever a text ends. Each result
// word the block hands over is compared field by field with the oldest queued
// expectation.
//
// The run has two parts. A short directed table comes first. Then come
// random phases, each of which programs a fresh pattern and sends a handful of
// texts built to contain the pattern, near misses of it, or noise.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    // Register index that no register answers to; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // A result word is registered in the cycle after the final byte is accepted; this leaves margin.
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_WORDS = 800;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    text_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 found;
    logic [INDEX_W-1:0]   match_index;
    logic                 text_overflow;

    substring_first_match_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_index  (match_index),
        .text_overflow(text_overflow)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state. The pattern registers mirror the block's registers,
    // and the rest is the per-text search state that a final byte clears.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  pat_len_reg = '0;
    logic [CFG_W-1:0]  pat_lo_reg = '0;
    logic [CFG_W-1:0]  pat_hi_reg = '0;
    logic [BYTE_W-1:0] recent_bytes [WIN_DEPTH];
    logic [POS_W-1:0]  text_pos = '0;
    bit                hit_seen = 1'b0;
    logic [POS_W-1:0]  hit_start = '0;

    result_t pending_results [$];
    int      error_count = 0;

    // Values that ride along with the input word. When pin_on is set, the
    // typed-in result replaces the predicted one for that word.
    bit      pin_on = 1'b0;
    result_t pin_res = '0;

    initial
    begin
        foreach (recent_bytes[k])
            recent_bytes[k] = '0;
    end

    // Pattern length in use; lengths above the maximum act as the maximum.
    function automatic int unsigned live_len();
        return (pat_len_reg > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(pat_len_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned pick);
        logic [PAT_W-1:0] pat;
        pat = {pat_hi_reg, pat_lo_reg};
        return pat[8 * pick +: 8];
    endfunction

    // Advances the search by one accepted byte. Returns 1 when the byte ends
    // a text, with the result word the block must give for that text.
    function automatic bit search_step(input logic [BYTE_W-1:0] b, input logic last,
                                       output result_t res);
        int unsigned len;
        int          k;
        bit          over;
        bit          same;
        len = live_len();
        res = '0;
        over = 1'b0;
        if (text_pos < MAX_TEXT_LEN)
        begin
            for (k = WIN_DEPTH - 1; k > 0; k--)
                recent_bytes[k] = recent_bytes[k - 1];
            recent_bytes[0] = b;
            text_pos = text_pos + 1'b1;
            // Only the first full match is recorded; the newest byte lines up
            // with the final pattern byte.
            if (len > 0 && !hit_seen && text_pos >= len)
            begin
                same = 1'b1;
                for (k = 0; k < int'(len); k++)
                    if (recent_bytes[len - 1 - k] != pattern_byte(k))
                        same = 1'b0;
                if (same)
                begin
                    hit_seen = 1'b1;
                    hit_start = POS_W'(text_pos - len);
                end
            end
        end
        else
            over = 1'b1;
        if (!last)
        begin
            // Park the counter past the limit so the final byte still reports it.
            if (over)
                text_pos = POS_W'(MAX_TEXT_LEN + 1);
            return 1'b0;
        end
        res.overflow = over || (text_pos > MAX_TEXT_LEN);
        res.found = (len == 0) || hit_seen;
        res.index = (len != 0 && hit_seen) ? hit_start[INDEX_W-1:0] : '0;
        foreach (recent_bytes[k])
            recent_bytes[k] = '0;
        text_pos = '0;
        hit_seen = 1'b0;
        hit_start = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor. At each rising edge the result side is checked first, then
    // the accepted input word advances the predictor. A result word can never
    // belong to the input word accepted at the same edge, so this order is
    // safe. Register writes update the mirrored registers last.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        result_t next_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: found %0d match_index %0d text_overflow %0d",
                           found, match_index, text_overflow);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        error_count++;
                    end
                    if (match_index !== want.index)
                    begin
                        $error("match_index: expected %0d, got %0d", want.index, match_index);
                        error_count++;
                    end
                    if (text_overflow !== want.overflow)
                    begin
                        $error("text_overflow: expected %0d, got %0d",
                               want.overflow, text_overflow);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (search_step(text_byte, last_byte, next_res))
                    pending_results.push_back(pin_on ? pin_res : next_res);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: pat_len_reg = cfg_data[LEN_W-1:0];
                    REG_PATTERN_LOW:    pat_lo_reg = cfg_data;
                    REG_PATTERN_HIGH:   pat_hi_reg = cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It switches between modes of its own: always ready, coin
    // flips, mostly ready, and long stalls, each held for a random stretch.
    // ------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 40);
        end
        else
            stall_left = stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sender. Words go out in bursts of random length with gaps between.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last,
                             input bit pinned, input result_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        text_byte <= b;
        last_byte <= last;
        pin_on <= pinned;
        pin_res <= want;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Stops sending and waits until every expected result word has arrived,
    // then lets the pipeline drain before anything touches the registers.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table. Rows are register writes or input words; a word that
    // ends a text may carry a typed-in result that is obvious by inspection.
    // ------------------------------------------------------------------
    typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        logic [BYTE_W-1:0]    chr;
        logic                 last;
        bit                   pinned;
        result_t              want;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
        plan_row_t r;
        r.kind = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = val;
        r.chr = '0;
        r.last = 1'b0;
        r.pinned = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_word(input logic [BYTE_W-1:0] b);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.reg_index = REG_PATTERN_LENGTH;
        r.reg_value = '0;
        r.chr = b;
        r.last = 1'b0;
        r.pinned = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_end(input logic [BYTE_W-1:0] b, input logic f,
                                     input logic [INDEX_W-1:0] at, input logic ovf);
        plan_row_t r;
        r.kind = ROW_WORD;
        r.reg_index = REG_PATTERN_LENGTH;
        r.reg_value = '0;
        r.chr = b;
        r.last = 1'b1;
        r.pinned = 1'b1;
        r.want.found = f;
        r.want.index = at;
        r.want.overflow = ovf;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [CFG_W-1:0] make_pattern_word();
        logic [CFG_W-1:0] w;
        int               k;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        for (k = 0; k < 8; k++)
        begin
            case ($urandom_range(0, 5))
                0:       w[8 * k +: 8] = 8'h00;
                1:       w[8 * k +: 8] = 8'hFF;
                2, 3:    w[8 * k +: 8] = 8'($urandom_range(0, 255));
                default: w[8 * k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
            endcase
        end
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] make_length_word();
        logic [CFG_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = MAX_PATTERN_LEN;
            2:       w = $urandom_range(MAX_PATTERN_LEN + 1, 31);
            3:       w = 1;
            default: w = $urandom_range(2, MAX_PATTERN_LEN - 1);
        endcase
        // Bits above the length field are don't-care; stir them now and then.
        if ($urandom_range(0, 7) == 0)
            w[CFG_W-1:LEN_W] = (CFG_W - LEN_W)'({$urandom, $urandom});
        return w;
    endfunction

    // Text bytes lean on the pattern's own bytes so near misses are common.
    function automatic logic [BYTE_W-1:0] make_text_byte();
        int unsigned len;
        len = live_len();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'h61 + 8'($urandom_range(0, 2));
            default: return pattern_byte($urandom_range(0, (len > 0) ? len - 1 : 0));
        endcase
    endfunction

    task automatic program_random_pattern();
        settle();
        write_reg(REG_PATTERN_LENGTH, make_length_word());
        write_reg(REG_PATTERN_LOW, make_pattern_word());
        write_reg(REG_PATTERN_HIGH, make_pattern_word());
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_SPARE, {$urandom, $urandom});
    endtask

    // Builds one text around the current pattern and sends it. Now and then
    // the text is cut in two by a register write while the text is open.
    task automatic send_random_text(inout int unsigned sent);
        logic [BYTE_W-1:0] txt [$];
        int unsigned       n;
        int unsigned       len;
        int unsigned       at;
        int unsigned       k;
        int unsigned       split;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        len = live_len();
        txt.delete();
        for (k = 0; k < n; k++)
            txt.push_back(make_text_byte());
        if (len > 0 && n >= len && $urandom_range(0, 4) < 3)
        begin
            repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
            begin
                at = $urandom_range(0, n - len);
                for (k = 0; k < len; k++)
                    txt[at + k] = pattern_byte(k);
            end
        end
        split = (n >= 2 && $urandom_range(0, 15) == 0) ? $urandom_range(1, n - 1) : 0;
        for (k = 0; k < n; k++)
        begin
            if (split != 0 && k == split)
            begin
                settle();
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_PATTERN_LENGTH, make_length_word());
                    1:       write_reg(REG_PATTERN_LOW, make_pattern_word());
                    default: write_reg(REG_PATTERN_HIGH, make_pattern_word());
                endcase
            end
            send_word(txt[k], k == n - 1, 1'b0, '0);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned sent;
        int unsigned k;

        // After reset the pattern is empty and matches at once.
        plan_end(8'h41, 1'b1, 16'd0, 1'b0);
        // Pattern "abc" found at position 1 of "xabca".
        plan_write(REG_PATTERN_LENGTH, 64'd3);
        plan_write(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
        plan_word(8'h78);
        plan_word(8'h61);
        plan_word(8'h62);
        plan_word(8'h63);
        plan_end(8'h61, 1'b1, 16'd1, 1'b0);
        // A text shorter than the pattern cannot match.
        plan_word(8'h61);
        plan_end(8'h62, 1'b0, 16'd0, 1'b0);
        // Full-length pattern of all ones, matched by a text of the same size.
        plan_write(REG_PATTERN_LENGTH, 64'd16);
        plan_write(REG_PATTERN_LOW, '1);
        plan_write(REG_PATTERN_HIGH, '1);
        for (k = 0; k < 15; k++)
            plan_word(8'hFF);
        plan_end(8'hFF, 1'b1, 16'd0, 1'b0);
        // A length beyond the maximum acts as the maximum, so one byte is short.
        plan_write(REG_PATTERN_LENGTH, 64'd31);
        plan_end(8'h00, 1'b0, 16'd0, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
                send_word(plan[i].chr, plan[i].last, plan[i].pinned, plan[i].want);
        end

        // Random phases: a fresh pattern, then a few texts against it.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            program_random_pattern();
            repeat ($urandom_range(3, 8))
                send_random_text(sent);
        end

        settle();
        repeat (10) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
